// File: design/lfcrc_pkg.sv
// ----------------------------------------------------------------------------
// lfcrc_pkg
// Shared types, codes, constants and the CRC16 byte update for the
// length-framed CRC16 receiver.
// ----------------------------------------------------------------------------
package lfcrc_pkg;

    // Default size of the frame store in bytes.
    localparam int FRAME_BYTES_MAX_DEF = 256;

    // Frame layout and CRC constants.
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam int          HEADER_BYTES = 4;
    localparam int          CRC_BYTES    = 2;

    // Register defaults after reset.
    localparam logic [15:0] TIMEOUT_DEF     = 16'd5;
    localparam logic [7:0]  MAX_PAYLOAD_DEF = 8'd250;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT     = 1'b0,
        REG_MAX_PAYLOAD = 1'b1
    } reg_idx_t;

    // Commands carried by an input transaction.
    typedef enum logic [2:0] {
        CMD_BYTE     = 3'd0,
        CMD_LINE_ERR = 3'd1,
        CMD_TICK     = 3'd2,
        CMD_READ     = 3'd3,
        CMD_RELEASE  = 3'd4
    } cmd_t;

    // Event codes reported with every result.
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_ACCEPT   = 3'd1,
        EV_CRC_BAD  = 3'd2,
        EV_LEN_REJ  = 3'd3,
        EV_OVERFLOW = 3'd4,
        EV_TIMEOUT  = 3'd5,
        EV_BUSY     = 3'd6,
        EV_ERROR    = 3'd7
    } ev_t;

    // Outcome of one command, handed from the parser to the output stage.
    typedef struct packed {
        logic       frame_ready;
        logic [8:0] frame_length;
        ev_t        evt;
        logic       rd_sel;
    } lfcrc_status_t;

    // Modbus CRC16 update by one byte, reflected, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: design/lfcrc_req_if.sv
// ----------------------------------------------------------------------------
// lfcrc_req_if
// Input channel: one command per transaction with its byte and read index.
// ----------------------------------------------------------------------------
interface lfcrc_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, cmd, rx_byte, read_index, input ready);
    modport sink   (input valid, cmd, rx_byte, read_index, output ready);
endinterface

// File: design/lfcrc_rsp_if.sv
// ----------------------------------------------------------------------------
// lfcrc_rsp_if
// Result channel: held-frame status, read byte and event code.
// ----------------------------------------------------------------------------
interface lfcrc_rsp_if;
    logic       valid;
    logic       ready;
    logic       frame_ready;
    logic [8:0] frame_length;
    logic [7:0] read_data;
    logic [2:0] event_res;

    modport source (output valid, frame_ready, frame_length, read_data, event_res,
                    input ready);
    modport sink   (input valid, frame_ready, frame_length, read_data, event_res,
                    output ready);
endinterface

// File: design/lfcrc_ram.sv
// ----------------------------------------------------------------------------
// lfcrc_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lfcrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lfcrc_parser.sv
// ----------------------------------------------------------------------------
// lfcrc_parser
// Frame parser: byte count, length, running CRC, silence timer, held frame
// and configuration registers. Drives the frame store's ports.
// ----------------------------------------------------------------------------
module lfcrc_parser
    import lfcrc_pkg::*;
#(
    parameter int FRAME_BYTES_MAX = FRAME_BYTES_MAX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_data,
    input  logic                               accept,
    input  logic [2:0]                         cmd,
    input  logic [7:0]                         rx_byte,
    input  logic [7:0]                         read_index,
    output lfcrc_status_t                      status,
    output logic                               mem_we,
    output logic [$clog2(FRAME_BYTES_MAX)-1:0] mem_waddr,
    output logic [7:0]                         mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(FRAME_BYTES_MAX)-1:0] mem_raddr
);

    localparam int AW = $clog2(FRAME_BYTES_MAX);
    localparam int CW = $clog2(FRAME_BYTES_MAX + 1);
    localparam int LW = (CW > 10) ? CW : 10;

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [8:0]    exp_len_reg, exp_len_next;
    logic [15:0]   crc_reg, crc_next;
    logic [15:0]   silence_reg, silence_next;
    logic          held_reg, held_next;
    logic [8:0]    held_len_reg, held_len_next;
    logic [7:0]    prev_byte_reg;
    logic [15:0]   timeout_reg;
    logic [7:0]    max_pl_reg;

    logic [CW-1:0] count_inc;
    logic [15:0]   silence_inc;
    logic [15:0]   pair_word;
    logic          parser_clr;
    logic          byte_stored;
    ev_t           evt;
    logic          rd_sel;

    assign count_inc   = byte_count_reg + CW'(1);
    assign silence_inc = (silence_reg == 16'hFFFF) ? silence_reg : silence_reg + 16'd1;
    // The current byte with the one before it, little-endian.
    assign pair_word   = {rx_byte, prev_byte_reg};

    // Next state of the parser for the command in this transaction.
    always_comb
    begin
        byte_count_next = byte_count_reg;
        exp_len_next    = exp_len_reg;
        crc_next        = crc_reg;
        silence_next    = silence_reg;
        held_next       = held_reg;
        held_len_next   = held_len_reg;
        parser_clr      = 1'b0;
        byte_stored     = 1'b0;
        evt             = EV_NONE;
        rd_sel          = 1'b0;

        unique case (cmd)
            CMD_BYTE:
            begin
                priority if (held_reg)
                begin
                    evt = EV_BUSY;
                end
                else if (byte_count_reg == CW'(FRAME_BYTES_MAX))
                begin
                    parser_clr = 1'b1;
                    evt        = EV_OVERFLOW;
                end
                else
                begin
                    byte_stored     = 1'b1;
                    byte_count_next = count_inc;
                    silence_next    = 16'd0;
                    // The CRC covers the header and the payload only.
                    if ((LW'(byte_count_reg) < LW'(HEADER_BYTES)) ||
                        ((exp_len_reg != 9'd0) &&
                         (LW'(byte_count_reg) < LW'(exp_len_reg) - LW'(CRC_BYTES))))
                    begin
                        crc_next = crc_byte(crc_reg, rx_byte);
                    end
                    priority if (LW'(count_inc) == LW'(HEADER_BYTES))
                    begin
                        // Length field complete: check it against the limit.
                        if (pair_word > {8'h00, max_pl_reg})
                        begin
                            parser_clr = 1'b1;
                            evt        = EV_LEN_REJ;
                        end
                        else
                        begin
                            exp_len_next = pair_word[8:0] + 9'(HEADER_BYTES + CRC_BYTES);
                        end
                    end
                    else if ((exp_len_reg != 9'd0) && (LW'(count_inc) == LW'(exp_len_reg)))
                    begin
                        // Last byte: compare the trailing CRC with the running one.
                        parser_clr = 1'b1;
                        if (pair_word == crc_reg)
                        begin
                            held_next     = 1'b1;
                            held_len_next = exp_len_reg;
                            evt           = EV_ACCEPT;
                        end
                        else
                        begin
                            evt = EV_CRC_BAD;
                        end
                    end
                    else
                    begin
                        evt = EV_NONE;
                    end
                end
            end
            CMD_LINE_ERR:
            begin
                parser_clr = 1'b1;
                evt        = EV_ERROR;
            end
            CMD_TICK:
            begin
                silence_next = silence_inc;
                if ((byte_count_reg != CW'(0)) && (silence_inc > timeout_reg))
                begin
                    parser_clr = 1'b1;
                    evt        = EV_TIMEOUT;
                end
            end
            CMD_READ:
            begin
                rd_sel = held_reg && ({1'b0, read_index} < held_len_reg);
            end
            CMD_RELEASE:
            begin
                held_next     = 1'b0;
                held_len_next = 9'd0;
            end
            default:
            begin
                evt = EV_NONE;
            end
        endcase

        if (parser_clr)
        begin
            byte_count_next = '0;
            exp_len_next    = 9'd0;
            crc_next        = CRC_INIT;
            silence_next    = 16'd0;
        end
    end

    // Parser state, updated once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            exp_len_reg    <= 9'd0;
            crc_reg        <= CRC_INIT;
            silence_reg    <= 16'd0;
            held_reg       <= 1'b0;
            held_len_reg   <= 9'd0;
        end
        else if (accept)
        begin
            byte_count_reg <= byte_count_next;
            exp_len_reg    <= exp_len_next;
            crc_reg        <= crc_next;
            silence_reg    <= silence_next;
            held_reg       <= held_next;
            held_len_reg   <= held_len_next;
        end
    end

    // Last stored byte, so the length and CRC fields need no store read.
    always_ff @(posedge clk)
    begin
        if (accept && byte_stored)
        begin
            prev_byte_reg <= rx_byte;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_DEF;
            max_pl_reg  <= MAX_PAYLOAD_DEF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:     timeout_reg <= cfg_data;
                REG_MAX_PAYLOAD: max_pl_reg  <= cfg_data[7:0];
                default:         timeout_reg <= timeout_reg;
            endcase
        end
    end

    // Frame store ports. Writes happen only while no frame is held, and
    // reads return data only while one is, so they never meet on an entry.
    assign mem_we    = accept && byte_stored;
    assign mem_waddr = byte_count_reg[AW-1:0];
    assign mem_wdata = rx_byte;
    assign mem_re    = accept && (cmd == CMD_READ);
    assign mem_raddr = AW'(read_index);

    assign status.frame_ready  = held_next;
    assign status.frame_length = held_len_next;
    assign status.evt          = evt;
    assign status.rd_sel       = rd_sel;

endmodule

// File: design/length_framed_crc16_receiver_core.sv
// ----------------------------------------------------------------------------
// length_framed_crc16_receiver_core
// Receiver for length-framed frames protected by a Modbus CRC16.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one command per transaction: a received byte, a
// line error, a millisecond tick, a read of the held frame or a release.
// Every request gives exactly one transaction on the rsp channel with the
// held-frame flag and length, the byte read and an event code.
// Frame bytes are written into a synchronous frame store as they arrive;
// length and CRC fields are checked from a running CRC and the last byte,
// so a byte needs no store read. Reads of the held frame go through the
// store's one read port, whose registered output feeds the result.
// A result is registered and offered in the cycle after the request; one
// request is taken every cycle. A result waiting in the output register
// does not stop a new request as long as the sink takes the old one in
// the same cycle; if the sink stalls, req.ready drops until it is taken.
// Reset clears the parser, the held frame and the registers to their
// defaults; the frame store is not cleared and needs no clearing pass.
// Configuration is written through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module length_framed_crc16_receiver_core
    import lfcrc_pkg::*;
#(
    parameter int FRAME_BYTES_MAX = FRAME_BYTES_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lfcrc_req_if.sink             req,
    lfcrc_rsp_if.source           rsp
);

    localparam int AW = $clog2(FRAME_BYTES_MAX);

    logic          accept;
    lfcrc_status_t status;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    logic          rsp_valid_reg;
    lfcrc_status_t status_reg;

    // A request is taken when the output register is empty or draining.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    lfcrc_parser #(
        .FRAME_BYTES_MAX (FRAME_BYTES_MAX)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .cmd        (req.cmd),
        .rx_byte    (req.rx_byte),
        .read_index (req.read_index),
        .status     (status),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr)
    );

    lfcrc_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES_MAX)
    ) u_frame_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded alongside the store read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.frame_ready  = status_reg.frame_ready;
    assign rsp.frame_length = status_reg.frame_length;
    assign rsp.read_data    = status_reg.rd_sel ? mem_rdata : 8'h00;
    assign rsp.event_res    = status_reg.evt;

endmodule

// File: design/lfcrc_checker.sv
// ----------------------------------------------------------------------------
// lfcrc_checker
// Port-level checks on the receiver's results, bound to the top level.
// ----------------------------------------------------------------------------
module lfcrc_checker
    import lfcrc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       frame_ready,
    input logic [8:0] frame_length,
    input logic [7:0] read_data,
    input logic [2:0] event_res
);

    // A held frame always has a length, and no length is shown without one.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (frame_ready == (frame_length != 9'd0)))
        else $error("held flag and frame length disagree");

    // A held frame is at least header plus CRC long.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && frame_ready) |-> (frame_length >= 9'(HEADER_BYTES + CRC_BYTES)))
        else $error("held frame shorter than header and CRC");

    // An accepted frame is reported as held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (event_res == EV_ACCEPT)) |-> frame_ready)
        else $error("frame accepted but not held");

    // Read data comes only from a held frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (read_data != 8'h00)) |-> frame_ready)
        else $error("read data without a held frame");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result withdrawn while stalled");

endmodule

bind length_framed_crc16_receiver_core lfcrc_checker u_lfcrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .frame_ready  (rsp.frame_ready),
    .frame_length (rsp.frame_length),
    .read_data    (rsp.read_data),
    .event_res    (rsp.event_res)
);
